/* src/swseg_pkg.sv */
// Package: shared types, register indexes and segment encoding for the stopwatch counter.
`timescale 1ns / 1ps
package swseg_pkg;

  localparam int COUNT_W = 14;
  localparam int TICK_W  = 8;
  localparam int DIGIT_W = 4;
  localparam int THOU_W  = 5;
  localparam int SEG_W   = 7;
  localparam int CFG_W   = 14;
  localparam int IDX_W   = 1;

  localparam logic [IDX_W-1:0]   REG_WRAP_LIMIT = 1'b0;
  localparam logic [IDX_W-1:0]   REG_PRESCALE   = 1'b1;

  localparam logic [COUNT_W-1:0] WRAP_LIMIT_RST = 14'd9999;
  localparam logic [TICK_W-1:0]  PRESCALE_RST   = 8'd5;

  localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  typedef struct packed {
    logic [THOU_W-1:0]  thousands;
    logic [DIGIT_W-1:0] hundreds;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] units;
  } digits_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SEG_W-1:0]   units;
    logic [SEG_W-1:0]   tens;
    logic [SEG_W-1:0]   hundreds;
    logic [SEG_W-1:0]   thousands;
  } result_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [THOU_W-1:0] digit);
    logic [SEG_W-1:0] code;
    if (digit > THOU_W'(9)) begin
      code = '0;
    end else begin
      code = SEG_TABLE[digit[DIGIT_W-1:0]];
    end
    return code;
  endfunction

endpackage

/* src/swseg_counter.sv */
// Counter state: prescaler, run flag, binary count and its decimal digits.
`timescale 1ns / 1ps
module swseg_counter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic                          start_n,
  input  logic                          pause_n,
  input  logic                          resume_n,
  input  logic [swseg_pkg::COUNT_W-1:0] wrap_limit,
  input  logic [swseg_pkg::TICK_W-1:0]  prescale,
  output logic [swseg_pkg::COUNT_W-1:0] count_next,
  output swseg_pkg::digits_t            digits_next
);
  import swseg_pkg::*;

  logic [COUNT_W-1:0] count;
  logic [TICK_W-1:0]  tick_count;
  logic [TICK_W-1:0]  tick_count_next;
  logic               running;
  logic               running_next;
  digits_t            digits;

  logic [COUNT_W-1:0] count_base;
  logic [COUNT_W-1:0] count_inc;
  digits_t            digits_base;
  digits_t            digits_inc;
  logic               run_base;
  logic [TICK_W-1:0]  tick_inc;
  logic               step;

  always_comb begin
    run_base    = running | ~start_n;
    count_base  = start_n ? count : '0;
    digits_base = start_n ? digits : '0;
    tick_inc    = tick_count + TICK_W'(1);
    step        = run_base && (tick_inc == prescale);

    count_inc = count_base + COUNT_W'(1);

    // decimal increment with carry
    digits_inc = digits_base;
    if (digits_base.units == DIGIT_W'(9)) begin
      digits_inc.units = '0;
      if (digits_base.tens == DIGIT_W'(9)) begin
        digits_inc.tens = '0;
        if (digits_base.hundreds == DIGIT_W'(9)) begin
          digits_inc.hundreds  = '0;
          digits_inc.thousands = digits_base.thousands + THOU_W'(1);
        end else begin
          digits_inc.hundreds = digits_base.hundreds + DIGIT_W'(1);
        end
      end else begin
        digits_inc.tens = digits_base.tens + DIGIT_W'(1);
      end
    end else begin
      digits_inc.units = digits_base.units + DIGIT_W'(1);
    end

    if (!run_base) begin
      tick_count_next = tick_count;
      count_next      = count_base;
      digits_next     = digits_base;
    end else if (!step) begin
      tick_count_next = tick_inc;
      count_next      = count_base;
      digits_next     = digits_base;
    end else begin
      tick_count_next = '0;
      if ((count_inc == wrap_limit) || (count_inc == '0)) begin
        count_next  = '0;
        digits_next = '0;
      end else begin
        count_next  = count_inc;
        digits_next = digits_inc;
      end
    end

    if (!resume_n) begin
      running_next = 1'b1;
    end else if (!pause_n) begin
      running_next = 1'b0;
    end else begin
      running_next = run_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      tick_count <= '0;
      running    <= 1'b0;
      digits     <= '0;
    end else if (take) begin
      count      <= count_next;
      tick_count <= tick_count_next;
      running    <= running_next;
      digits     <= digits_next;
    end
  end

endmodule

/* src/stopwatch_counter_seven_segment_core.sv */
// Top level: four-digit stopwatch up counter with seven-segment result and skid output.
// A tick's result is registered in the output register, or in the skid register while the output stalls.
// Throughput: one tick per cycle while in_stall is low; the counter update and segment lookup sit in one stage.
// A two-entry output (result register plus skid register) keeps input open while a result waits.
// Reset: synchronous, active high; count, prescaler and run flag clear, output empties,
// wrap limit returns to 9999 and prescale to 5.
`timescale 1ns / 1ps
module stopwatch_counter_seven_segment_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [swseg_pkg::IDX_W-1:0]   cfg_index,
  input  logic [swseg_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          start_n,
  input  logic                          pause_n,
  input  logic                          resume_n,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swseg_pkg::COUNT_W-1:0] count_out,
  output logic [swseg_pkg::SEG_W-1:0]   seg_units,
  output logic [swseg_pkg::SEG_W-1:0]   seg_tens,
  output logic [swseg_pkg::SEG_W-1:0]   seg_hundreds,
  output logic [swseg_pkg::SEG_W-1:0]   seg_thousands
);
  import swseg_pkg::*;

  logic [COUNT_W-1:0] wrap_limit;
  logic [TICK_W-1:0]  prescale;

  logic               take;
  logic [COUNT_W-1:0] count_next;
  digits_t            digits_next;
  result_t            res_new;
  result_t            res_out;
  result_t            res_skid;
  logic               skid_valid;
  logic               out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_limit <= WRAP_LIMIT_RST;
      prescale   <= PRESCALE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WRAP_LIMIT: wrap_limit <= cfg_data[COUNT_W-1:0];
        REG_PRESCALE:   prescale   <= cfg_data[TICK_W-1:0];
        default:        ;
      endcase
    end
  end

  assign in_stall = skid_valid;
  assign take     = in_valid & ~skid_valid;
  assign out_free = ~out_valid | ~out_stall;

  swseg_counter u_counter (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .start_n     (start_n),
    .pause_n     (pause_n),
    .resume_n    (resume_n),
    .wrap_limit  (wrap_limit),
    .prescale    (prescale),
    .count_next  (count_next),
    .digits_next (digits_next)
  );

  always_comb begin
    res_new.count     = count_next;
    res_new.units     = seg_of({1'b0, digits_next.units});
    res_new.tens      = seg_of({1'b0, digits_next.tens});
    res_new.hundreds  = seg_of({1'b0, digits_next.hundreds});
    res_new.thousands = seg_of(digits_next.thousands);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= skid_valid | take;
      end
      if (skid_valid && out_free) begin
        skid_valid <= 1'b0;
      end else if (take && !out_free) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && out_free) begin
      res_out <= res_skid;
    end else if (take) begin
      if (out_free) begin
        res_out <= res_new;
      end else begin
        res_skid <= res_new;
      end
    end
  end

  assign count_out     = res_out.count;
  assign seg_units     = res_out.units;
  assign seg_tens      = res_out.tens;
  assign seg_hundreds  = res_out.hundreds;
  assign seg_thousands = res_out.thousands;

endmodule

/* tb/swseg_display_checker.sv */
// Checker: predicts the stopwatch count and segment codes and compares each output transfer.
`timescale 1ns / 1ps
module swseg_display_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [swseg_pkg::IDX_W-1:0]   cfg_index,
  input  logic [swseg_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          start_n,
  input  logic                          pause_n,
  input  logic                          resume_n,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [swseg_pkg::COUNT_W-1:0] count_out,
  input  logic [swseg_pkg::SEG_W-1:0]   seg_units,
  input  logic [swseg_pkg::SEG_W-1:0]   seg_tens,
  input  logic [swseg_pkg::SEG_W-1:0]   seg_hundreds,
  input  logic [swseg_pkg::SEG_W-1:0]   seg_thousands,
  output int                            errors,
  output int                            outstanding
);
  import swseg_pkg::*;

  logic [COUNT_W-1:0] wrap_lim;
  logic [TICK_W-1:0]  presc;
  logic [COUNT_W-1:0] count_val;
  logic [TICK_W-1:0]  ticks;
  logic               running;
  result_t            display_q[$];

  function automatic logic [SEG_W-1:0] digit_code(input int d);
    case (d)
      0: return 7'h3F;
      1: return 7'h06;
      2: return 7'h5B;
      3: return 7'h4F;
      4: return 7'h66;
      5: return 7'h6D;
      6: return 7'h7D;
      7: return 7'h07;
      8: return 7'h7F;
      9: return 7'h6F;
      default: return '0;
    endcase
  endfunction

  function automatic result_t next_display(input logic s_n, input logic p_n, input logic r_n);
    result_t r;
    int v;
    if (!s_n) begin
      count_val = '0;
      running = 1'b1;
    end
    if (running) begin
      ticks = ticks + 1'b1;
      if (ticks == presc) begin
        ticks = '0;
        count_val = count_val + 1'b1;
        if (count_val == wrap_lim) begin
          count_val = '0;
        end
      end
    end
    if (!p_n) begin
      running = 1'b0;
    end
    if (!r_n) begin
      running = 1'b1;
    end
    v = int'(count_val);
    r.count = count_val;
    r.units = digit_code(v % 10);
    r.tens = digit_code((v / 10) % 10);
    r.hundreds = digit_code((v / 100) % 10);
    r.thousands = digit_code(v / 1000);
    return r;
  endfunction

  function automatic int field_check(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : compare_proc
    result_t want;
    int bad;
    bad = 0;
    if (rst) begin
      wrap_lim = WRAP_LIMIT_RST;
      presc = PRESCALE_RST;
      count_val = '0;
      ticks = '0;
      running = 1'b0;
      display_q.delete();
      errors <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_WRAP_LIMIT: wrap_lim = cfg_data[COUNT_W-1:0];
          REG_PRESCALE:   presc = cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (display_q.size() == 0) begin
          $error("unexpected transfer: count_out=%0d", count_out);
          bad = 1;
        end else begin
          want = display_q.pop_front();
          bad = field_check("count_out", 32'(want.count), 32'(count_out))
              + field_check("seg_units", 32'(want.units), 32'(seg_units))
              + field_check("seg_tens", 32'(want.tens), 32'(seg_tens))
              + field_check("seg_hundreds", 32'(want.hundreds), 32'(seg_hundreds))
              + field_check("seg_thousands", 32'(want.thousands), 32'(seg_thousands));
        end
      end
      if (in_valid && !in_stall) begin
        display_q.push_back(next_display(start_n, pause_n, resume_n));
      end
      errors <= errors + bad;
      outstanding <= display_q.size();
    end
  end

endmodule

/* tb/testbench.sv */
// Testbench top: drives ticks and register writes into the stopwatch core and gives the verdict.
`timescale 1ns / 1ps
module testbench;
  import swseg_pkg::*;

  localparam int HOLD_CYCLES = 50;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [IDX_W-1:0]   cfg_index = REG_WRAP_LIMIT;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               start_n = 1'b1;
  logic               pause_n = 1'b1;
  logic               resume_n = 1'b1;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [COUNT_W-1:0] count_out;
  logic [SEG_W-1:0]   seg_units;
  logic [SEG_W-1:0]   seg_tens;
  logic [SEG_W-1:0]   seg_hundreds;
  logic [SEG_W-1:0]   seg_thousands;
  int                 errors;
  int                 outstanding;
  logic               rx_gaps = 1'b0;
  logic               press = 1'b0;
  bit                 tx_gaps;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stopwatch_counter_seven_segment_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_n(start_n), .pause_n(pause_n), .resume_n(resume_n),
    .out_valid(out_valid), .out_stall(out_stall),
    .count_out(count_out), .seg_units(seg_units), .seg_tens(seg_tens),
    .seg_hundreds(seg_hundreds), .seg_thousands(seg_thousands)
  );

  swseg_display_checker i_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_n(start_n), .pause_n(pause_n), .resume_n(resume_n),
    .out_valid(out_valid), .out_stall(out_stall),
    .count_out(count_out), .seg_units(seg_units), .seg_tens(seg_tens),
    .seg_hundreds(seg_hundreds), .seg_thousands(seg_thousands),
    .errors(errors), .outstanding(outstanding)
  );

  task automatic send_tick(input logic s, input logic p, input logic r);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_n <= s;
    pause_n <= p;
    resume_n <= r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic released_ticks(input int n);
    repeat (n) send_tick(1'b1, 1'b1, 1'b1);
  endtask

  task automatic random_ticks(input int n);
    repeat (n) begin
      send_tick($urandom_range(0, 15) != 0, $urandom_range(0, 9) != 0,
                $urandom_range(0, 7) != 0);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_config(input int wrap, input int presc);
    write_reg(REG_WRAP_LIMIT, CFG_W'(wrap));
    write_reg(REG_PRESCALE, CFG_W'(presc));
  endtask

  // receiver: random stall bursts, plus one long hold-off under pressure
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (press && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int wrap;
    int presc;
    tx_gaps = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    rx_gaps <= 1'b1;

    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);
    released_ticks(3);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    released_ticks(6);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    released_ticks(2);

    set_config(1, 1);
    released_ticks(4);
    set_config(9999, 255);
    released_ticks(3);
    // lower prescale to 200, then to zero below the running tick count, and run on prescale zero
    set_config(9999, 200);
    released_ticks(100);
    set_config(9999, 0);
    released_ticks(300);

    // sync the prescaler, count up, then drop the wrap limit below the count
    set_config(0, 1);
    send_tick(1'b0, 1'b1, 1'b1);
    released_ticks(150);
    set_config(100, 1);
    released_ticks(20);

    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 5))
        0: wrap = 1;
        1: wrap = 9999;
        2: wrap = $urandom_range(2, 30);
        3: wrap = 0;
        4: wrap = $urandom_range(0, 16383);
        default: wrap = $urandom_range(10, 200);
      endcase
      case ($urandom_range(0, 4))
        0: presc = 1;
        1: presc = $urandom_range(1, 4);
        2: presc = 255;
        3: presc = 0;
        default: presc = $urandom_range(0, 255);
      endcase
      set_config(wrap, presc);
      tx_gaps = $urandom_range(0, 3) != 0;
      rx_gaps <= $urandom_range(0, 3) != 0;
      send_tick(1'b0, 1'b1, 1'b1);
      random_ticks($urandom_range(40, 70));
      if (ph == 3) begin
        // fill the core while the receiver holds off
        tx_gaps = 1'b0;
        press <= 1'b1;
        random_ticks(60);
        press <= 1'b0;
      end
    end

    set_config(20, 1);
    tx_gaps = 1'b0;
    rx_gaps <= 1'b0;
    random_ticks(80);

    settle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
